FILE: hw/rtl/hsbd_pkg.sv
// ----------------------------------------------------------------------------
// hsbd_pkg
// Shared types and constants for the sampled-bit HDLC deframer.
// ----------------------------------------------------------------------------
package hsbd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CD_W      = 18;
    localparam int SR_W      = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONF_MIN    = 3'd0,
        CFG_HALF_BIT    = 3'd1,
        CFG_PERIOD_WHOLE = 3'd2,
        CFG_PERIOD_REM  = 3'd3,
        CFG_BAUD        = 3'd4
    } cfg_idx_t;

    localparam logic [6:0]  CONF_MIN_RST     = 7'd10;
    localparam logic [15:0] HALF_BIT_RST     = 16'd13;
    localparam logic [15:0] PERIOD_WHOLE_RST = 16'd26;
    localparam logic [15:0] PERIOD_REM_RST   = 16'd200;
    localparam logic [15:0] BAUD_RST         = 16'd300;

    localparam logic signed [CD_W-1:0] CD_MIN = {1'b1, {(CD_W-1){1'b0}}};

    localparam logic [7:0] FLAG_BYTE     = 8'h7E;
    localparam logic [5:0] STUFF_PATTERN = 6'h3E;

    localparam logic EVT_DATA = 1'b0;
    localparam logic EVT_FLAG = 1'b1;

    typedef struct packed {
        logic [6:0]  confidence_minimum;
        logic [15:0] half_bit_samples;
        logic [15:0] bit_period_whole;
        logic [15:0] bit_period_remainder;
        logic [15:0] baud_rate;
    } cfg_t;

    typedef struct packed {
        logic       level;
        logic [6:0] confidence;
    } sample_t;

    typedef struct packed {
        logic take;
        logic level;
    } bit_evt_t;

endpackage

FILE: hw/rtl/hsbd_cfg_regs.sv
// ----------------------------------------------------------------------------
// hsbd_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module hsbd_cfg_regs import hsbd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CONF_MIN:     cfg_next.confidence_minimum   = cfg_data[6:0];
                CFG_HALF_BIT:     cfg_next.half_bit_samples     = cfg_data;
                CFG_PERIOD_WHOLE: cfg_next.bit_period_whole     = cfg_data;
                CFG_PERIOD_REM:   cfg_next.bit_period_remainder = cfg_data;
                CFG_BAUD:         cfg_next.baud_rate            = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.confidence_minimum   <= CONF_MIN_RST;
            cfg_reg.half_bit_samples     <= HALF_BIT_RST;
            cfg_reg.bit_period_whole     <= PERIOD_WHOLE_RST;
            cfg_reg.bit_period_remainder <= PERIOD_REM_RST;
            cfg_reg.baud_rate            <= BAUD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/hsbd_in_stage.sv
// ----------------------------------------------------------------------------
// hsbd_in_stage
// Input register for one sample item.
// ----------------------------------------------------------------------------
module hsbd_in_stage import hsbd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_sample_bit,
    input  logic [6:0] s_confidence,
    input  logic       advance,
    output logic       in_valid,
    output sample_t    sample
);

    logic    valid_reg;
    logic    valid_next;
    sample_t sample_reg;

    assign s_ready  = !valid_reg || advance;
    assign in_valid = valid_reg;
    assign sample   = sample_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg.level      <= s_sample_bit;
            sample_reg.confidence <= s_confidence;
        end
    end

endmodule

FILE: hw/rtl/hsbd_bit_sync.sv
// ----------------------------------------------------------------------------
// hsbd_bit_sync
// Bit clock recovery: sample countdown, fractional period accumulator and
// resync on level change.
// ----------------------------------------------------------------------------
module hsbd_bit_sync import hsbd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     advance,
    input  sample_t  sample,
    output bit_evt_t bit_evt
);

    logic                   seen_reg, seen_next;
    logic                   level_reg, level_next;
    logic signed [CD_W-1:0] cd_reg, cd_next;
    logic [15:0]            frac_reg, frac_next;

    logic signed [CD_W-1:0] cd_dec;
    logic signed [CD_W-1:0] cd_reload;
    logic                   confident;
    logic                   change;
    logic [16:0]            frac_sum;
    logic [16:0]            frac_red;
    logic                   carry;
    logic                   take;

    always_comb begin
        cd_dec    = (cd_reg == CD_MIN) ? cd_reg : cd_reg - 18'sd1;
        confident = sample.confidence >= cfg.confidence_minimum;
        change    = !seen_reg || (level_reg != sample.level);
        frac_sum  = {1'b0, frac_reg} + {1'b0, cfg.bit_period_remainder};
        carry     = frac_sum >= {1'b0, cfg.baud_rate};
        frac_red  = carry ? frac_sum - {1'b0, cfg.baud_rate} : frac_sum;
        cd_reload = cd_dec + $signed({2'b00, cfg.bit_period_whole})
                  + $signed({{(CD_W-1){1'b0}}, carry});
        take      = advance && confident && !change && !(cd_dec > 18'sd0);
    end

    always_comb begin
        seen_next  = seen_reg;
        level_next = level_reg;
        cd_next    = cd_reg;
        frac_next  = frac_reg;
        if (advance) begin
            cd_next = cd_dec;
            if (confident) begin
                if (change) begin
                    seen_next  = 1'b1;
                    level_next = sample.level;
                    cd_next    = $signed({2'b00, cfg.half_bit_samples});
                    frac_next  = '0;
                end else if (take) begin
                    frac_next = frac_red[15:0];
                    cd_next   = cd_reload;
                end
            end
        end
    end

    assign bit_evt.take  = take;
    assign bit_evt.level = sample.level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= 1'b0;
            level_reg <= 1'b0;
            cd_reg    <= '0;
            frac_reg  <= '0;
        end else begin
            seen_reg  <= seen_next;
            level_reg <= level_next;
            cd_reg    <= cd_next;
            frac_reg  <= frac_next;
        end
    end

    a_resync_loads_half: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && confident && change
        |=> cd_reg == $signed({2'b00, $past(cfg.half_bit_samples)}) && frac_reg == '0)
        else $error("resync did not load half bit countdown");

    a_take_needs_level: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> seen_reg && level_reg == sample.level)
        else $error("bit taken without a stable level");

    a_no_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !confident && $past(aresetn) && cd_reg == CD_MIN |=> cd_reg == CD_MIN)
        else $error("countdown wrapped past its minimum");

endmodule

FILE: hw/rtl/hsbd_deframer.sv
// ----------------------------------------------------------------------------
// hsbd_deframer
// Flag detection, zero-bit removal, byte assembly and result register.
// ----------------------------------------------------------------------------
module hsbd_deframer import hsbd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  bit_evt_t   bit_evt,
    input  logic       m_ready,
    output logic       m_valid,
    output logic       m_event_kind,
    output logic [7:0] m_byte_value
);

    logic [SR_W-1:0] sr_reg, sr_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic            guard_reg, guard_next;
    logic            m_valid_reg, m_valid_next;
    logic            kind_reg;
    logic [7:0]      byte_reg;

    logic [SR_W-1:0] sr_shift;
    logic [2:0]      cnt_inc;
    logic            is_flag;
    logic            is_stuff;
    logic            emit;
    logic            emit_kind;

    always_comb begin
        sr_shift   = {sr_reg[SR_W-2:0], bit_evt.level};
        cnt_inc    = cnt_reg + 3'd1;
        is_flag    = sr_shift[7:0] == FLAG_BYTE;
        is_stuff   = !is_flag && !guard_reg && sr_shift[5:0] == STUFF_PATTERN;
        sr_next    = sr_reg;
        cnt_next   = cnt_reg;
        guard_next = guard_reg;
        emit       = 1'b0;
        emit_kind  = EVT_DATA;
        if (bit_evt.take) begin
            sr_next    = sr_shift;
            cnt_next   = cnt_inc;
            guard_next = 1'b0;
            if (is_flag) begin
                cnt_next  = '0;
                emit      = 1'b1;
                emit_kind = EVT_FLAG;
            end else if (is_stuff) begin
                sr_next    = {1'b0, sr_shift[SR_W-1:1]};
                cnt_next   = cnt_reg;
                guard_next = 1'b1;
            end else if (cnt_inc == 3'd0) begin
                emit = 1'b1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = kind_reg;
    assign m_byte_value = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sr_reg      <= '0;
            cnt_reg     <= '0;
            guard_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            sr_reg      <= sr_next;
            cnt_reg     <= cnt_next;
            guard_reg   <= guard_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg <= emit_kind;
            byte_reg <= sr_shift[7:0];
        end
    end

    a_flag_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && kind_reg == EVT_FLAG |-> byte_reg == FLAG_BYTE)
        else $error("flag item without flag byte");

    a_flag_realigns: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_evt.take && is_flag |=> cnt_reg == '0)
        else $error("byte alignment not restarted on flag");

    a_guard_one_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_evt.take && guard_reg |-> !is_stuff)
        else $error("zero bit removed twice in a row");

    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid_reg)
        else $error("result item lost");

endmodule

FILE: hw/rtl/hdlc_sampled_bit_deframer_unit.sv
// ----------------------------------------------------------------------------
// hdlc_sampled_bit_deframer_unit
// HDLC deframer with bit clock recovery from a stream of line samples.
// ----------------------------------------------------------------------------
// One sample item is accepted per clock cycle. Each item goes through an input
// register and one pass of clock recovery and bit deframing logic; a completed
// data byte or flag lands in the result register, which drives the m_ channel.
// Throughput is one item per cycle and is limited only by m_ready; the input
// side stalls when the result register is full and not taken. Configuration
// must be written while the block is idle; the block does not enforce it.
module hdlc_sampled_bit_deframer_unit import hsbd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_sample_bit,
    input  logic [6:0]           s_confidence,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_event_kind,
    output logic [7:0]           m_byte_value,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    cfg_t     cfg;
    sample_t  sample;
    bit_evt_t bit_evt;
    logic     in_valid;
    logic     advance;

    assign advance = in_valid && (!m_valid || m_ready);

    hsbd_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hsbd_in_stage u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_bit (s_sample_bit),
        .s_confidence (s_confidence),
        .advance      (advance),
        .in_valid     (in_valid),
        .sample       (sample)
    );

    hsbd_bit_sync u_bit_sync (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .sample  (sample),
        .bit_evt (bit_evt)
    );

    hsbd_deframer u_deframer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .bit_evt      (bit_evt),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_event_kind (m_event_kind),
        .m_byte_value (m_byte_value)
    );

endmodule
